>>> src/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    // bus phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_RECOV,
        PH_SLOT
    } phase_t;

    // command codes of a request
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam int CFG_WIDTH       = 10;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_REGS        = 7;

    // register indexes
    localparam int REG_RESET_LOW    = 0;
    localparam int REG_PRESENCE     = 1;
    localparam int REG_RECOVERY     = 2;
    localparam int REG_WRITE_ONE    = 3;
    localparam int REG_WRITE_ZERO   = 4;
    localparam int REG_SLOT_LENGTH  = 5;
    localparam int REG_READ_SAMPLE  = 6;

    localparam logic [CFG_WIDTH-1:0] REG_DEFAULTS [NUM_REGS] = '{
        10'd480, 10'd70, 10'd410, 10'd6, 10'd60, 10'd70, 10'd15
    };

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

>>> src/owm_if.sv
// ----------------------------------------------------------------------------
// owm_if
// Request and result channels of the one-wire bus master.
// ----------------------------------------------------------------------------
interface owm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       line_in;

    modport source (output valid, output cmd, output tx_byte, output line_in, input ready);
    modport sink   (input valid, input cmd, input tx_byte, input line_in, output ready);
endinterface

interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output rx_byte, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input rx_byte, input rejected, output ready);
endinterface

>>> src/owm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file with effective times limited to the timer range.
// ----------------------------------------------------------------------------
module owm_cfg_regs #(
    parameter int TIMER_WIDTH = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [owm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [owm_pkg::CFG_WIDTH-1:0]         cfg_wdata,
    output logic [TIMER_WIDTH-1:0]                eff_time [owm_pkg::NUM_REGS]
);
    import owm_pkg::*;

    localparam int CMAX = (1 << TIMER_WIDTH) - 1;

    logic [CFG_WIDTH-1:0] regs_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= REG_DEFAULTS[i];
            end
        end
        else if (cfg_wr_en && (int'(cfg_index) < NUM_REGS))
        begin
            regs_reg[cfg_index] <= cfg_wdata;
        end
    end

    // zero reads as one, values past the timer saturate
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (regs_reg[i] == '0)
            begin
                eff_time[i] = TIMER_WIDTH'(1);
            end
            else if (int'(regs_reg[i]) > CMAX)
            begin
                eff_time[i] = '1;
            end
            else
            begin
                eff_time[i] = TIMER_WIDTH'(regs_reg[i]);
            end
        end
    end

endmodule

>>> src/onewire_bus_master.sv
// ----------------------------------------------------------------------------
// onewire_bus_master
// Open-drain one-wire master: reset with presence detect, byte write, byte read.
// ----------------------------------------------------------------------------
// Every request is either a command (reset, write byte, read byte) or a tick
// that marks one microsecond and carries the sampled bus level; each request
// gives exactly one result with the drive level to apply, busy, a done pulse,
// the held presence flag, the read byte on the done of a read, and a reject
// flag for commands that arrive while an operation runs. The block takes one
// request per clock cycle: the request is decoded against the phase register
// and timer in a single combinational pass and the result lands in an output
// register, and a new request is taken whenever that register is empty or
// being read in the same cycle. Bus timing is counted in ticks, not clocks,
// so the upstream prescaler sets real time. The user must write timing
// registers only while the bus is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module onewire_bus_master #(
    parameter int TIMER_WIDTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [owm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [owm_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    owm_cmd_if.sink                             cmd_ch,
    owm_res_if.source                           res_ch
);
    import owm_pkg::*;

    // effective timing values
    logic [TIMER_WIDTH-1:0] eff_time [NUM_REGS];
    logic [TIMER_WIDTH-1:0] samp_time;
    logic [TIMER_WIDTH-1:0] low_time;

    // bus state
    phase_t                 phase_reg,     phase_next;
    logic [TIMER_WIDTH-1:0] time_reg,      time_next;
    logic [2:0]             bit_reg,       bit_next;
    logic [7:0]             shift_reg,     shift_next;
    logic                   presence_reg,  presence_next;
    logic                   is_read_reg,   is_read_next;

    // result register
    logic       res_valid_reg;
    logic       drive_reg,    drive_next;
    logic       busy_reg,     busy_next;
    logic       done_reg,     done_next;
    logic       pres_out_reg;
    logic [7:0] rx_reg,       rx_next;
    logic       rej_reg,      rej_next;

    logic                   cmd_fire;
    logic [TIMER_WIDTH-1:0] time_inc;
    cmd_t                   cmd_code;

    owm_cfg_regs #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .eff_time  (eff_time)
    );

    // take a request while the result slot is free or draining
    assign cmd_ch.ready = !res_valid_reg || res_ch.ready;
    assign cmd_fire     = cmd_ch.valid && cmd_ch.ready;
    assign cmd_code     = cmd_t'(cmd_ch.cmd);
    assign time_inc     = time_reg + TIMER_WIDTH'(1);

    // read sample never later than the last tick of the slot
    assign samp_time = (eff_time[REG_READ_SAMPLE] > eff_time[REG_SLOT_LENGTH]) ?
                       eff_time[REG_SLOT_LENGTH] : eff_time[REG_READ_SAMPLE];

    // next state and result of one request
    always_comb
    begin
        phase_next    = phase_reg;
        time_next     = time_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        is_read_next  = is_read_reg;
        done_next     = 1'b0;
        rej_next      = 1'b0;
        rx_next       = '0;

        if (cmd_code != CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                // busy: drop the command, time stands still
                rej_next = 1'b1;
            end
            else if (cmd_code == CMD_RESET)
            begin
                phase_next    = PH_RST_LOW;
                time_next     = '0;
                presence_next = 1'b0;
            end
            else
            begin
                phase_next   = PH_SLOT;
                time_next    = '0;
                bit_next     = '0;
                is_read_next = (cmd_code == CMD_READ);
                shift_next   = (cmd_code == CMD_READ) ? 8'h00 : cmd_ch.tx_byte;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    // a tick with nothing running changes nothing
                end
                PH_RST_LOW:
                begin
                    time_next = time_inc;
                    if (time_inc == eff_time[REG_RESET_LOW])
                    begin
                        phase_next = PH_RST_WAIT;
                        time_next  = '0;
                    end
                end
                PH_RST_WAIT:
                begin
                    time_next = time_inc;
                    if (time_inc == eff_time[REG_PRESENCE])
                    begin
                        // a device answers by holding the line low
                        presence_next = !cmd_ch.line_in;
                        phase_next    = PH_RST_RECOV;
                        time_next     = '0;
                    end
                end
                PH_RST_RECOV:
                begin
                    time_next = time_inc;
                    if (time_inc == eff_time[REG_RECOVERY])
                    begin
                        phase_next = PH_IDLE;
                        time_next  = '0;
                        done_next  = 1'b1;
                    end
                end
                PH_SLOT:
                begin
                    time_next = time_inc;
                    // read bits enter at the top, lsb ends up first
                    if (is_read_reg && (time_inc == samp_time))
                    begin
                        shift_next = {cmd_ch.line_in, shift_reg[7:1]};
                    end
                    if (time_inc == eff_time[REG_SLOT_LENGTH])
                    begin
                        if (!is_read_reg)
                        begin
                            shift_next = shift_reg >> 1;
                        end
                        time_next = '0;
                        if (bit_reg == LAST_BIT)
                        begin
                            phase_next = PH_IDLE;
                            bit_next   = '0;
                            done_next  = 1'b1;
                            if (is_read_reg)
                            begin
                                rx_next = shift_next;
                            end
                        end
                        else
                        begin
                            bit_next = bit_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // drive level after this request
    assign low_time  = (is_read_next || shift_next[0]) ?
                       eff_time[REG_WRITE_ONE] : eff_time[REG_WRITE_ZERO];
    assign drive_next = (phase_next == PH_RST_LOW) ||
                        ((phase_next == PH_SLOT) && (time_next < low_time));
    assign busy_next  = (phase_next != PH_IDLE);

    // bus state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            time_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            is_read_reg  <= 1'b0;
        end
        else if (cmd_fire)
        begin
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            is_read_reg  <= is_read_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            drive_reg    <= drive_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            pres_out_reg <= presence_next;
            rx_reg       <= rx_next;
            rej_reg      <= rej_next;
        end
    end

    assign res_ch.valid     = res_valid_reg;
    assign res_ch.drive_low = drive_reg;
    assign res_ch.busy_res  = busy_reg;
    assign res_ch.done_res  = done_reg;
    assign res_ch.presence  = pres_out_reg;
    assign res_ch.rx_byte   = rx_reg;
    assign res_ch.rejected  = rej_reg;

    // an idle bus keeps its timer and bit counter cleared
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> ((time_reg == '0) && (bit_reg == '0)))
        else $error("idle bus with running counters");

    // the line is only pulled while an operation runs
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && drive_reg) |-> busy_reg)
        else $error("line driven while not busy");

    // finishing leaves the bus idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && done_reg) |-> !busy_reg)
        else $error("done with bus still busy");

    // a dropped command never completes anything and the bus stays busy
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && rej_reg) |-> (busy_reg && !done_reg))
        else $error("reject with inconsistent status");

    // a read byte shows only on a done result
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (rx_reg != 8'h00)) |-> done_reg)
        else $error("read byte outside done");

endmodule

>>> tb/onewire_bus_master_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master_test
// Self-checking bench for the one-wire master: bus reset with presence,
// byte write and byte read slots, rejects while busy, timing register edges.
// A short stimulus table comes first, then random operation sequences under
// several timing settings. Every request is mirrored in a cycle-free bus
// model and each result is checked in order against it.
// ----------------------------------------------------------------------------
module onewire_bus_master_test;
    import owm_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 70;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_REPORTS   = 10;
    localparam int GAP_PERCENT   = 17;
    localparam logic [CFG_INDEX_WIDTH-1:0] SPARE_INDEX = 3'd7;
    localparam logic [CFG_WIDTH-1:0]       TIME_MAX    = 10'd1023;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
        logic       rejected;
    } bus_result_t;

    typedef logic [NUM_REGS-1:0][CFG_WIDTH-1:0] reg_set_t;

    // which timing set a table row loads before it is sent
    typedef enum {KEEP_SET, TINY_SET, READ_SET} set_pick_t;

    typedef struct {
        set_pick_t   load;
        cmd_t        cmd;
        logic [7:0]  tx;
        logic        line;
        bit          typed;
        bus_result_t want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_wdata;

    owm_cmd_if cmd_ch ();
    owm_res_if res_ch ();

    onewire_bus_master uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_ch    (cmd_ch),
        .res_ch    (res_ch)
    );

    // bus model state, mirrors the block after every accepted request
    phase_t               bus_phase;
    logic [CFG_WIDTH-1:0] tick_count;
    logic [2:0]           bit_pos;
    logic [7:0]           shreg;
    logic                 saw_presence;
    logic                 reading;
    logic [CFG_WIDTH-1:0] reg_copy [NUM_REGS];

    bus_result_t bus_results_due [$];
    stim_row_t   stim_table [$];
    int          mismatches = 0;
    int          cycles     = 0;
    bit          no_gaps    = 1'b0;
    bus_result_t seen;
    bus_result_t wanted;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // bus model
    // ------------------------------------------------------------------------

    // a zero register counts as one tick
    function automatic logic [CFG_WIDTH-1:0] span(int idx);
        return (reg_copy[idx] == '0) ? CFG_WIDTH'(1) : reg_copy[idx];
    endfunction

    function automatic bus_result_t predict_bus(cmd_t c, logic [7:0] tx, logic ln);
        bus_result_t          r;
        logic [CFG_WIDTH-1:0] slot_len;
        logic [CFG_WIDTH-1:0] samp_at;
        logic [CFG_WIDTH-1:0] low_len;
        r = '0;
        if (c != CMD_TICK)
        begin
            // a command is not a tick: no time passes
            if (bus_phase != PH_IDLE)
                r.rejected = 1'b1;
            else if (c == CMD_RESET)
            begin
                bus_phase    = PH_RST_LOW;
                tick_count   = '0;
                saw_presence = 1'b0;
            end
            else
            begin
                bus_phase  = PH_SLOT;
                tick_count = '0;
                bit_pos    = '0;
                reading    = (c == CMD_READ);
                shreg      = reading ? 8'h00 : tx;
            end
        end
        else if (bus_phase != PH_IDLE)
        begin
            tick_count = tick_count + 1'b1;
            case (bus_phase)
                PH_RST_LOW:
                    if (tick_count == span(REG_RESET_LOW))
                    begin
                        bus_phase  = PH_RST_WAIT;
                        tick_count = '0;
                    end
                PH_RST_WAIT:
                    if (tick_count == span(REG_PRESENCE))
                    begin
                        saw_presence = ~ln;
                        bus_phase    = PH_RST_RECOV;
                        tick_count   = '0;
                    end
                PH_RST_RECOV:
                    if (tick_count == span(REG_RECOVERY))
                    begin
                        bus_phase  = PH_IDLE;
                        tick_count = '0;
                        r.done_res = 1'b1;
                    end
                default:
                begin
                    slot_len = span(REG_SLOT_LENGTH);
                    samp_at  = span(REG_READ_SAMPLE);
                    // a late sample falls on the last tick of the slot
                    if (samp_at > slot_len)
                        samp_at = slot_len;
                    if (reading && tick_count == samp_at)
                        shreg = {ln, shreg[7:1]};
                    if (tick_count == slot_len)
                    begin
                        if (!reading)
                            shreg = shreg >> 1;
                        tick_count = '0;
                        if (bit_pos == LAST_BIT)
                        begin
                            bus_phase  = PH_IDLE;
                            bit_pos    = '0;
                            r.done_res = 1'b1;
                            if (reading)
                                r.rx_byte = shreg;
                        end
                        else
                            bit_pos = bit_pos + 1'b1;
                    end
                end
            endcase
        end
        if (bus_phase == PH_RST_LOW)
            r.drive_low = 1'b1;
        else if (bus_phase == PH_SLOT)
        begin
            low_len     = (reading || shreg[0]) ? span(REG_WRITE_ONE) : span(REG_WRITE_ZERO);
            r.drive_low = (tick_count < low_len);
        end
        r.busy_res = (bus_phase != PH_IDLE);
        r.presence = saw_presence;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    function automatic bus_result_t bus_res(logic d, logic b, logic dn, logic p,
                                            logic [7:0] rx, logic rj);
        bus_res = {d, b, dn, p, rx, rj};
    endfunction

    function automatic stim_row_t row(set_pick_t ld, cmd_t c, logic [7:0] tx, logic ln,
                                      bit typed, bus_result_t want);
        row.load  = ld;
        row.cmd   = c;
        row.tx    = tx;
        row.line  = ln;
        row.typed = typed;
        row.want  = want;
    endfunction

    function automatic reg_set_t make_set(int rl, int pw, int rr, int w1, int w0,
                                          int sl, int rs);
        make_set[REG_RESET_LOW]   = CFG_WIDTH'(rl);
        make_set[REG_PRESENCE]    = CFG_WIDTH'(pw);
        make_set[REG_RECOVERY]    = CFG_WIDTH'(rr);
        make_set[REG_WRITE_ONE]   = CFG_WIDTH'(w1);
        make_set[REG_WRITE_ZERO]  = CFG_WIDTH'(w0);
        make_set[REG_SLOT_LENGTH] = CFG_WIDTH'(sl);
        make_set[REG_READ_SAMPLE] = CFG_WIDTH'(rs);
    endfunction

    // one request: random gap, offer it, wait for the handshake, log the result owed
    task automatic push_request(cmd_t c, logic [7:0] tx, logic ln, bit typed,
                                bus_result_t want);
        bus_result_t guess;
        while (!no_gaps && $urandom_range(99) < GAP_PERCENT)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.cmd     <= c;
        cmd_ch.tx_byte <= tx;
        cmd_ch.line_in <= ln;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        guess = predict_bus(c, tx, ln);
        bus_results_due.push_back(typed ? want : guess);
    endtask

    task automatic send_tick();
        push_request(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    task automatic send_stray_cmd();
        push_request(cmd_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // tick the running operation out, with the odd stray command on the way
    task automatic run_to_idle();
        while (bus_phase != PH_IDLE)
        begin
            if ($urandom_range(99) < 4)
                send_stray_cmd();
            else
                send_tick();
        end
    endtask

    task automatic wait_results();
        cmd_ch.valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // timing registers change only with the bus idle and no result in flight
    task automatic load_settings(reg_set_t s);
        run_to_idle();
        wait_results();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_INDEX_WIDTH'(i);
            cfg_wdata <= s[i];
            @(posedge clk);
            reg_copy[i] = s[i];
        end
        // the spare index has no register behind it
        cfg_wr_en <= 1'b1;
        cfg_index <= SPARE_INDEX;
        cfg_wdata <= CFG_WIDTH'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n, bit hold_mid);
        logic [7:0] tx;
        int         pick;
        for (int k = 0; k < n; k++)
        begin
            if (hold_mid && k == n / 2)
                wait_results();
            pick = $urandom_range(9);
            tx   = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            if (bus_phase == PH_IDLE && $urandom_range(99) >= 20)
                push_request(cmd_t'($urandom_range(1, 3)), tx, 1'($urandom), 1'b0, '0);
            else if (bus_phase != PH_IDLE && $urandom_range(99) < 5)
                send_stray_cmd();
            else
                send_tick();
        end
    endtask

    task automatic run_op(cmd_t c);
        push_request(c, 8'($urandom), 1'($urandom), 1'b0, '0);
        run_to_idle();
    endtask

    // ------------------------------------------------------------------------
    // result side: random backpressure and in-order checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen = bus_res(res_ch.drive_low, res_ch.busy_res, res_ch.done_res,
                           res_ch.presence, res_ch.rx_byte, res_ch.rejected);
            if (bus_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: %s",
                             $time, $sformatf("drv=%b busy=%b done=%b pres=%b rx=%h rej=%b",
                             seen.drive_low, seen.busy_res, seen.done_res,
                             seen.presence, seen.rx_byte, seen.rejected));
            end
            else
            begin
                wanted = bus_results_due.pop_front();
                if (seen.drive_low !== wanted.drive_low || seen.busy_res !== wanted.busy_res ||
                    seen.done_res !== wanted.done_res || seen.presence !== wanted.presence ||
                    seen.rx_byte !== wanted.rx_byte || seen.rejected !== wanted.rejected)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("%0t: mismatch exp drv=%b busy=%b done=%b pres=%b rx=%h rej=%b",
                               $time, wanted.drive_low, wanted.busy_res, wanted.done_res,
                               wanted.presence, wanted.rx_byte, wanted.rejected);
                        $display(", got drv=%b busy=%b done=%b pres=%b rx=%h rej=%b",
                                 seen.drive_low, seen.busy_res, seen.done_res,
                                 seen.presence, seen.rx_byte, seen.rejected);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        reg_set_t tiny_set;
        reg_set_t read_set;
        reg_set_t default_set;
        reg_set_t phase_set;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.cmd     = CMD_TICK;
        cmd_ch.tx_byte = 8'h00;
        cmd_ch.line_in = 1'b1;

        bus_phase    = PH_IDLE;
        tick_count   = '0;
        bit_pos      = '0;
        shreg        = 8'h00;
        saw_presence = 1'b0;
        reading      = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            reg_copy[i]    = REG_DEFAULTS[i];
            default_set[i] = REG_DEFAULTS[i];
        end

        // zero reset low time, write-zero low longer than the slot, sample past the slot
        tiny_set = make_set(0, 1, 1, 1, 3, 2, 5);
        read_set = make_set(2, 3, 1, 2, 4, 5, 3);

        //                    load      cmd        tx     line typed expected
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 1, bus_res(0, 0, 0, 0, 8'h00, 0)));
        stim_table.push_back(row(TINY_SET, CMD_RESET, 8'h00, 1'b0, 1, bus_res(1, 1, 0, 0, 8'h00, 0)));
        stim_table.push_back(row(KEEP_SET, CMD_WRITE, 8'hFF, 1'b1, 1, bus_res(1, 1, 0, 0, 8'h00, 1)));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        // line low at the end of the wait: a device answered
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h5A, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_READ,  8'h00, 1'b1, 1, bus_res(0, 1, 0, 1, 8'h00, 1)));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'hFF, 1'b0, 0, '0));
        // second reset, nobody answers
        stim_table.push_back(row(KEEP_SET, CMD_RESET, 8'hFF, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        // write of all zeros: every slot held low throughout
        stim_table.push_back(row(KEEP_SET, CMD_WRITE, 8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_RESET, 8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        // read with the sample inside the slot
        stim_table.push_back(row(READ_SET, CMD_READ,  8'hFF, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_WRITE, 8'hA5, 1'b0, 0, '0));
        stim_table.push_back(row(KEEP_SET, CMD_TICK,  8'h00, 1'b1, 0, '0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].load == TINY_SET)
                load_settings(tiny_set);
            else if (stim_table[i].load == READ_SET)
                load_settings(read_set);
            push_request(stim_table[i].cmd, stim_table[i].tx, stim_table[i].line,
                         stim_table[i].typed, stim_table[i].want);
        end

        // random sequences under short timing; one phase all zero, one with
        // saturated low and sample times, one with no gaps on either side
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_set = make_set($urandom_range(0, 8), $urandom_range(0, 8),
                                 $urandom_range(0, 8), $urandom_range(0, 7),
                                 $urandom_range(0, 7), $urandom_range(0, 7),
                                 $urandom_range(0, 8));
            if (p == 0)
                phase_set = '0;
            if (p == 2)
            begin
                phase_set[REG_WRITE_ONE]   = '0;
                phase_set[REG_WRITE_ZERO]  = TIME_MAX;
                phase_set[REG_READ_SAMPLE] = TIME_MAX;
            end
            load_settings(phase_set);
            no_gaps = (p == 4);
            random_phase(PHASE_ITEMS, p == 1);
        end
        no_gaps = 1'b0;

        // power-on timing, one full byte read
        load_settings(default_set);
        run_op(CMD_READ);

        wait_results();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
